FILE: hw/rtl/mhash_pkg.sv
// ----------------------------------------------------------------------------
// mhash_pkg
// Shared types and constants of the streaming 32-bit word hash.
// ----------------------------------------------------------------------------
package mhash_pkg;

    localparam logic [31:0] MixMult = 32'h5bd1e995;
    localparam int unsigned MixShift = 24;
    localparam int unsigned FinShiftA = 13;
    localparam int unsigned FinShiftB = 15;

    localparam int unsigned QueueDepthDefault = 2;

    // What the back end has to do with one queued word
    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_TAIL,
        KIND_FULL
    } word_kind_t;

    typedef struct packed {
        logic [31:0] word;
        word_kind_t  kind;
        logic        seed;
        logic [31:0] seed_value;
        logic        last;
    } mhash_entry_t;

    typedef struct packed {
        logic empty;
        logic full;
    } mhash_queue_stat_t;

    typedef struct packed {
        logic busy;
        logic finishing;
    } mhash_back_stat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MIX_W,
        ST_MIX_K,
        ST_MIX_H,
        ST_MIX_C,
        ST_TAIL,
        ST_TAIL_C,
        ST_FIN_A,
        ST_FIN_B
    } back_state_t;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_WORD,
        MUL_K,
        MUL_HASH,
        MUL_TAIL,
        MUL_FIN
    } mul_sel_t;

endpackage

FILE: hw/rtl/mhash_if.sv
// ----------------------------------------------------------------------------
// mhash_if
// Valid/ready channels for key words in and hash results out.
// ----------------------------------------------------------------------------
interface mhash_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] key_word;
    logic [2:0]  valid_bytes;
    logic        first_item;
    logic        last_item;
    logic [31:0] key_length;

    modport source (
        output valid, key_word, valid_bytes, first_item, last_item, key_length,
        input  ready
    );
    modport sink (
        input  valid, key_word, valid_bytes, first_item, last_item, key_length,
        output ready
    );
endinterface

interface mhash_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] hash_value;

    modport source (
        output valid, hash_value,
        input  ready
    );
    modport sink (
        input  valid, hash_value,
        output ready
    );
endinterface

FILE: hw/rtl/mhash_front.sv
// ----------------------------------------------------------------------------
// mhash_front
// Accepts key words, saturates the byte count, masks tail bytes and
// classifies each item into a queue entry.
// ----------------------------------------------------------------------------
module mhash_front (
    mhash_in_if.sink                   key_in,
    input  mhash_pkg::mhash_queue_stat_t queue_stat,
    output logic                       push,
    output mhash_pkg::mhash_entry_t    entry
);
    import mhash_pkg::*;

    logic [31:0] tail_mask;

    assign key_in.ready = !queue_stat.full;
    assign push         = key_in.valid && key_in.ready;

    always_comb
    begin
        unique case (key_in.valid_bytes[1:0])
            2'd1:    tail_mask = 32'h0000_00ff;
            2'd2:    tail_mask = 32'h0000_ffff;
            2'd3:    tail_mask = 32'h00ff_ffff;
            default: tail_mask = 32'h0000_0000;
        endcase
    end

    always_comb
    begin
        entry.seed       = key_in.first_item;
        entry.seed_value = key_in.key_length;
        entry.last       = key_in.last_item;
        // counts of four and above are a full word
        if (key_in.valid_bytes[2])
        begin
            entry.kind = KIND_FULL;
            entry.word = key_in.key_word;
        end
        else if (key_in.valid_bytes[1:0] != 2'd0)
        begin
            entry.kind = KIND_TAIL;
            entry.word = key_in.key_word & tail_mask;
        end
        else
        begin
            entry.kind = KIND_NONE;
            entry.word = 32'h0;
        end
    end

endmodule

FILE: hw/rtl/mhash_queue.sv
// ----------------------------------------------------------------------------
// mhash_queue
// Small register queue between the front end and the mixing sequencer.
// ----------------------------------------------------------------------------
module mhash_queue #(
    parameter int unsigned DEPTH = mhash_pkg::QueueDepthDefault
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  mhash_pkg::mhash_entry_t      push_data,
    input  logic                         pop,
    output mhash_pkg::mhash_entry_t      pop_data,
    output mhash_pkg::mhash_queue_stat_t stat
);
    import mhash_pkg::*;

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

    mhash_entry_t    slot_reg [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] count_next;

    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == FullCnt);
    assign pop_data   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

FILE: hw/rtl/mhash_back.sv
// ----------------------------------------------------------------------------
// mhash_back
// Mixing sequencer: one shared 32x32 multiplier with a registered product,
// stepped through word mix, tail fold and final avalanche.
// ----------------------------------------------------------------------------
module mhash_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  mhash_pkg::mhash_queue_stat_t queue_stat,
    input  mhash_pkg::mhash_entry_t      q_data,
    output logic                         pop,
    mhash_out_if.source                  hash_out,
    output mhash_pkg::mhash_back_stat_t  stat
);
    import mhash_pkg::*;

    back_state_t state_reg;
    back_state_t state_next;
    mul_sel_t    mul_sel;
    logic        out_load;

    logic [31:0] word_reg;
    logic        last_reg;
    logic [31:0] hash_reg;
    logic [31:0] prod_reg;
    logic [31:0] k_reg;
    logic [31:0] mul_op;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [31:0] out_hash_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!queue_stat.empty)
                begin
                    unique case (q_data.kind)
                        KIND_FULL: state_next = ST_MIX_W;
                        KIND_TAIL: state_next = ST_TAIL;
                        default:   state_next = q_data.last ? ST_FIN_A : ST_IDLE;
                    endcase
                end
            end
            ST_MIX_W:  state_next = ST_MIX_K;
            ST_MIX_K:  state_next = ST_MIX_H;
            ST_MIX_H:  state_next = ST_MIX_C;
            ST_MIX_C:  state_next = last_reg ? ST_FIN_A : ST_IDLE;
            ST_TAIL:   state_next = ST_TAIL_C;
            ST_TAIL_C: state_next = last_reg ? ST_FIN_A : ST_IDLE;
            ST_FIN_A:  state_next = ST_FIN_B;
            ST_FIN_B:  state_next = out_load ? ST_IDLE : ST_FIN_B;
            default:   state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        pop      = 1'b0;
        mul_sel  = MUL_NONE;
        out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE:  pop = !queue_stat.empty;
            ST_MIX_W: mul_sel = MUL_WORD;
            ST_MIX_K: mul_sel = MUL_K;
            ST_MIX_H: mul_sel = MUL_HASH;
            ST_TAIL:  mul_sel = MUL_TAIL;
            ST_FIN_A: mul_sel = MUL_FIN;
            // hold the finished value until the output slot frees up
            ST_FIN_B: out_load = !out_valid_reg || hash_out.ready;
            default:  mul_sel = MUL_NONE;
        endcase
    end

    always_comb
    begin
        unique case (mul_sel)
            MUL_WORD: mul_op = word_reg;
            MUL_K:    mul_op = prod_reg ^ (prod_reg >> MixShift);
            MUL_HASH: mul_op = hash_reg;
            MUL_TAIL: mul_op = hash_reg ^ word_reg;
            MUL_FIN:  mul_op = hash_reg ^ (hash_reg >> FinShiftA);
            default:  mul_op = prod_reg;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (hash_out.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            hash_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (pop && q_data.seed)
                hash_reg <= q_data.seed_value;
            else if (state_reg == ST_MIX_C)
                hash_reg <= prod_reg ^ k_reg;
            else if (state_reg == ST_TAIL_C)
                hash_reg <= prod_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            word_reg <= q_data.word;
            last_reg <= q_data.last;
        end
        if (mul_sel != MUL_NONE)
            prod_reg <= mul_op * MixMult;
        // keep the mixed key word while the hash is multiplied
        if (state_reg == ST_MIX_H)
            k_reg <= prod_reg;
        if (out_load)
            out_hash_reg <= prod_reg ^ (prod_reg >> FinShiftB);
    end

    assign hash_out.valid      = out_valid_reg;
    assign hash_out.hash_value = out_hash_reg;

    assign stat.busy      = (state_reg != ST_IDLE);
    assign stat.finishing = (state_reg == ST_FIN_B);

endmodule

FILE: hw/rtl/murmur2_stream_hash.sv
// ----------------------------------------------------------------------------
// murmur2_stream_hash
// 32-bit multiplicative hash of a key streamed as little-endian words.
//
//   channel    dir  handshake     payload
//   key_in     in   valid/ready   key_word, valid_bytes, first_item,
//                                 last_item, key_length
//   hash_out   out  valid/ready   hash_value
//
// A full word steps through MIX_W, MIX_K, MIX_H and MIX_C, a tail word
// through TAIL and TAIL_C; a last item adds FIN_A and FIN_B for the avalanche.
// All products use one shared registered 32x32 multiplier; it sets the rate.
// The input queue keeps taking items while the sequencer works; the result
// register lets the next item proceed while a hash waits to be taken.
// Reset clears the running hash to zero and empties the queue.
// ----------------------------------------------------------------------------
module murmur2_stream_hash #(
    parameter int unsigned QUEUE_DEPTH = mhash_pkg::QueueDepthDefault
) (
    input  logic        clk,
    input  logic        rst_n,
    mhash_in_if.sink    key_in,
    mhash_out_if.source hash_out
);
    import mhash_pkg::*;

    logic              q_push;
    logic              q_pop;
    mhash_entry_t      q_in;
    mhash_entry_t      q_out;
    mhash_queue_stat_t q_stat;
    mhash_back_stat_t  b_stat;

    mhash_front u_front (
        .key_in     (key_in),
        .queue_stat (q_stat),
        .push       (q_push),
        .entry      (q_in)
    );

    mhash_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .pop_data  (q_out),
        .stat      (q_stat)
    );

    mhash_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .queue_stat (q_stat),
        .q_data     (q_out),
        .pop        (q_pop),
        .hash_out   (hash_out),
        .stat       (b_stat)
    );

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("queue popped while empty");

    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (q_push && !q_pop) |=> !q_stat.empty)
        else $error("accepted item missing from queue");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(hash_out.valid) |-> $past(b_stat.finishing && b_stat.busy))
        else $error("result appeared without a finished avalanche");

endmodule

FILE: tb/sv/murmur2_stream_hash_test.sv
// ----------------------------------------------------------------------------
// murmur2_stream_hash_test
// Drives keys into murmur2_stream_hash and checks every emitted hash.
// A short table of fixed items comes first: corner values, tails, saturated
// byte counts and broken framing. Random keys with random content follow,
// mixed with unframed items. The sender and receiver idle at random.
// Every hash is compared with a local model of the running hash.
// ----------------------------------------------------------------------------
module murmur2_stream_hash_test;

    timeunit 1ns;
    timeprecision 1ps;

    import mhash_pkg::*;

    localparam int unsigned RandomItems = 1000;
    localparam int unsigned DrainCycles = 32;
    localparam int unsigned MaxGap = 30;
    localparam int unsigned NumRows = 19;

    typedef struct packed {
        logic [31:0] key_word;
        logic [2:0]  valid_bytes;
        logic        first_item;
        logic        last_item;
        logic [31:0] key_length;
    } key_item_t;

    typedef struct packed {
        key_item_t   item;
        logic        pinned;
        logic [31:0] pinned_hash;
    } key_row_t;

    // Pinned hashes are those that follow from a zero running hash
    key_row_t key_rows [NumRows] = '{
        '{'{32'hFFFFFFFF, 3'd0, 1'b0, 1'b1, 32'hFFFFFFFF}, 1'b1, 32'h00000000},
        '{'{32'h00000000, 3'd0, 1'b1, 1'b1, 32'h00000000}, 1'b1, 32'h00000000},
        '{'{32'hFFFFFFFF, 3'd4, 1'b1, 1'b1, 32'hFFFFFFFF}, 1'b0, 32'h00000000},
        '{'{32'h00000000, 3'd4, 1'b1, 1'b1, 32'h00000004}, 1'b0, 32'h00000000},
        '{'{32'h12345678, 3'd4, 1'b1, 1'b0, 32'h00000007}, 1'b0, 32'h00000000},
        '{'{32'hAABBCCDD, 3'd3, 1'b0, 1'b1, 32'hFFFFFFFF}, 1'b0, 32'h00000000},
        '{'{32'hFFFFFFFF, 3'd1, 1'b1, 1'b1, 32'h00000001}, 1'b0, 32'h00000000},
        '{'{32'hFFFFFFFF, 3'd2, 1'b1, 1'b1, 32'h00000002}, 1'b0, 32'h00000000},
        '{'{32'hFFFFFFFF, 3'd3, 1'b1, 1'b1, 32'h00000003}, 1'b0, 32'h00000000},
        '{'{32'h80000001, 3'd7, 1'b1, 1'b0, 32'h00000008}, 1'b0, 32'h00000000},
        '{'{32'h7FFFFFFE, 3'd5, 1'b0, 1'b1, 32'h00000000}, 1'b0, 32'h00000000},
        '{'{32'hDEADBEEF, 3'd6, 1'b1, 1'b1, 32'h00000004}, 1'b0, 32'h00000000},
        '{'{32'h000000A5, 3'd1, 1'b1, 1'b0, 32'h00000009}, 1'b0, 32'h00000000},
        '{'{32'h0000C3C3, 3'd2, 1'b0, 1'b0, 32'h00000000}, 1'b0, 32'h00000000},
        '{'{32'h01020304, 3'd4, 1'b0, 1'b1, 32'h00000000}, 1'b0, 32'h00000000},
        '{'{32'h55555555, 3'd4, 1'b0, 1'b1, 32'h00000000}, 1'b0, 32'h00000000},
        '{'{32'hAAAAAAAA, 3'd0, 1'b1, 1'b0, 32'h00000003}, 1'b0, 32'h00000000},
        '{'{32'h00FFFFFF, 3'd3, 1'b0, 1'b1, 32'h00000005}, 1'b0, 32'h00000000},
        '{'{32'hFFFFFFFF, 3'd0, 1'b0, 1'b0, 32'hFFFFFFFF}, 1'b0, 32'h00000000}
    };

    logic clk;
    logic rst_n;

    mhash_in_if  key_ch ();
    mhash_out_if hash_ch ();

    murmur2_stream_hash dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .key_in   (key_ch),
        .hash_out (hash_ch)
    );

    logic [31:0]   key_hash;
    logic [31:0]   hash_expect_q [$];
    int unsigned   fail_count = 0;
    int unsigned   items_sent;
    int unsigned   sender_idle_pct;
    int unsigned   receiver_stall_pct;
    logic          drive_pinned;
    logic [31:0]   drive_pinned_hash;

    function automatic logic [31:0] mix_full_word(logic [31:0] h, logic [31:0] w);
        logic [31:0] k;
        k = w * MixMult;
        k = k ^ (k >> MixShift);
        k = k * MixMult;
        return (h * MixMult) ^ k;
    endfunction

    function automatic logic [31:0] fold_tail_bytes(logic [31:0] h, logic [31:0] w,
                                                    logic [2:0] n);
        logic [31:0] mask;
        if (n == 3'd0)
        begin
            return h;
        end
        mask = (n == 3'd1) ? 32'h000000FF : (n == 3'd2) ? 32'h0000FFFF : 32'h00FFFFFF;
        return (h ^ (w & mask)) * MixMult;
    endfunction

    function automatic logic [31:0] avalanche_hash(logic [31:0] h);
        logic [31:0] f;
        f = h ^ (h >> FinShiftA);
        f = f * MixMult;
        return f ^ (f >> FinShiftB);
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            hash_ch.ready <= 1'b0;
        else
            hash_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Advance the model on each accepted item, then check each taken hash
    always @(posedge clk)
    begin : track_hash
        logic [31:0] h;
        logic [31:0] want;
        if (!rst_n)
            key_hash = '0;
        if (rst_n && key_ch.valid && key_ch.ready)
        begin
            h = key_ch.first_item ? key_ch.key_length : key_hash;
            if (key_ch.valid_bytes >= 3'd4)
                h = mix_full_word(h, key_ch.key_word);
            else
                h = fold_tail_bytes(h, key_ch.key_word, key_ch.valid_bytes);
            key_hash = h;
            if (key_ch.last_item)
            begin
                hash_expect_q.push_back(drive_pinned ? drive_pinned_hash
                                                     : avalanche_hash(h));
            end
        end
        if (rst_n && hash_ch.valid && hash_ch.ready)
        begin
            if (hash_expect_q.size() == 0)
            begin
                $error("hash_value: none expected, actual %08h", hash_ch.hash_value);
                fail_count++;
            end
            else
            begin
                want = hash_expect_q.pop_front();
                if (hash_ch.hash_value !== want)
                begin
                    $error("hash_value: expected %08h, actual %08h",
                           want, hash_ch.hash_value);
                    fail_count++;
                end
            end
        end
    end

    task automatic send_item(input key_item_t it, input logic pinned,
                             input logic [31:0] pinned_hash);
        int unsigned gap;
        gap = 0;
        while (gap < MaxGap && $urandom_range(99) < sender_idle_pct)
            gap++;
        if (gap > 0)
        begin
            key_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        key_ch.valid <= 1'b1;
        key_ch.key_word <= it.key_word;
        key_ch.valid_bytes <= it.valid_bytes;
        key_ch.first_item <= it.first_item;
        key_ch.last_item <= it.last_item;
        key_ch.key_length <= it.key_length;
        drive_pinned <= pinned;
        drive_pinned_hash <= pinned_hash;
        do
            @(posedge clk);
        while (!key_ch.ready);
        items_sent++;
    endtask

    // Well-formed key, now and then with a wrong length or no first flag
    task automatic send_random_key();
        int unsigned len;
        int unsigned remain;
        logic [31:0] klen;
        logic        drop_first;
        key_item_t   it;
        len = ($urandom_range(9) == 0) ? $urandom_range(64) : $urandom_range(16);
        klen = ($urandom_range(7) == 0) ? $urandom() : len;
        drop_first = ($urandom_range(19) == 0);
        remain = len;
        do
        begin
            it.key_word = $urandom();
            it.valid_bytes = 3'((remain >= 4) ? 4 : remain);
            it.first_item = (remain == len) && !drop_first;
            remain -= it.valid_bytes;
            it.last_item = (remain == 0);
            it.key_length = it.first_item ? klen : $urandom();
            send_item(it, 1'b0, '0);
        end
        while (remain != 0);
    endtask

    initial
    begin : run_test
        key_item_t noise;
        rst_n = 1'b0;
        key_ch.valid = 1'b0;
        key_ch.key_word = '0;
        key_ch.valid_bytes = '0;
        key_ch.first_item = 1'b0;
        key_ch.last_item = 1'b0;
        key_ch.key_length = '0;
        drive_pinned = 1'b0;
        drive_pinned_hash = '0;
        items_sent = 0;
        sender_idle_pct = 24;
        receiver_stall_pct = 79;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NumRows; i++)
            send_item(key_rows[i].item, key_rows[i].pinned, key_rows[i].pinned_hash);

        items_sent = 0;
        while (items_sent < RandomItems)
        begin
            if (items_sent >= 2 * RandomItems / 3)
            begin
                sender_idle_pct = 0;
                receiver_stall_pct = 0;
            end
            else if (items_sent >= RandomItems / 3)
            begin
                sender_idle_pct = 79;
                receiver_stall_pct = 24;
            end
            if ($urandom_range(9) == 0)
            begin
                noise.key_word = $urandom();
                noise.valid_bytes = 3'($urandom_range(7));
                noise.first_item = ($urandom_range(3) == 0);
                noise.last_item = ($urandom_range(3) == 0);
                noise.key_length = $urandom();
                send_item(noise, 1'b0, '0);
            end
            else
            begin
                send_random_key();
            end
        end
        key_ch.valid <= 1'b0;

        while (hash_expect_q.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);

        if (fail_count == 0)
            $display("murmur2_stream_hash test passed");
        else
            $display("murmur2_stream_hash test failed");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("murmur2_stream_hash test failed");
        $finish;
    end

endmodule
